// File: hw/rtl/gvpt_pkg.sv
// Package for the greedy vocabulary prefix tokenizer.
// Holds the shared constants and the item kind, register index and state types.
// Used by greedy_vocab_prefix_tokenizer.
package gvpt_pkg;

   localparam int VOCAB_DEPTH_DEF = 1024;
   localparam int MAX_PIECE_DEF   = 20;
   localparam int LEN_W           = 5;
   localparam int LEN_SLOTS       = 32;
   localparam int HDR_W           = LEN_W + 64;
   localparam logic [31:0] DJB2_SEED = 32'd5381;
   localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_TEXT   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_MODEL  = 3'd0,
      REG_SCORES = 3'd1,
      REG_IDS    = 3'd2,
      REG_COUNT  = 3'd3,
      REG_LIMIT  = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_PICK,
      ST_HASH,
      ST_EMIT
   } state_type;

endpackage

// File: hw/rtl/gvpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the vocabulary header and byte stores.
module gvpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/greedy_vocab_prefix_tokenizer.sv
// Greedy vocabulary prefix tokenizer: header and byte words write the vocabulary memories directly.
// A text word keeps it busy: per token, a scan (one entry per scan cycle), a pick of the length, a djb2
// hash unless a stored id is used, and the emit; with no vocabulary, only the hash and the emit.
// Each token appears on the rsp_ ports for one cycle with rsp_strobe; the receiver cannot stall.
// Synchronous reset clears the control registers, window and counters, not the payloads or memories.
// Depends on gvpt_pkg and gvpt_ram.
module greedy_vocab_prefix_tokenizer #(
   parameter int VOCAB_DEPTH = gvpt_pkg::VOCAB_DEPTH_DEF,
   parameter int MAX_PIECE   = gvpt_pkg::MAX_PIECE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [9:0]  req_entry_index,
   input  logic [4:0]  req_char_pos,
   input  logic [7:0]  req_byte_value,
   input  logic [4:0]  req_entry_len,
   input  logic [31:0] req_entry_id,
   input  logic signed [31:0] req_entry_score,
   input  logic        req_last_byte,
   output logic        rsp_strobe,
   output logic [31:0] rsp_tok_id,
   output logic [31:0] rsp_begin_pos,
   output logic [31:0] rsp_end_pos,
   output logic        rsp_last_token
);

   localparam int AW  = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
   localparam int CW  = $clog2(VOCAB_DEPTH + 1);
   localparam int FW  = $clog2(MAX_PIECE + 1);
   localparam int WIW = (MAX_PIECE > 1) ? $clog2(MAX_PIECE) : 1;
   localparam int LW  = gvpt_pkg::LEN_W;
   localparam int NL  = gvpt_pkg::LEN_SLOTS;

   gvpt_pkg::state_type state_ff, state_in;

   // Configuration registers.
   logic        model_ff, scores_ff, ids_ff;
   logic [10:0] count_ff;
   logic [15:0] limit_ff;

   // Text state.
   logic [7:0]    win_ff [MAX_PIECE];
   logic [7:0]    win_in [MAX_PIECE];
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0]   offset_ff, offset_in;
   logic [15:0]   tokens_ff, tokens_in;
   logic          last_ff, last_in;

   // Decision state.
   logic [CW-1:0]      scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [NL-1:0]      seen_ff, seen_in;
   logic signed [31:0] fscore_ff [NL];
   logic [31:0]        fid_ff [NL];
   logic               first_we;
   logic [LW-1:0]      first_sel;
   logic [5:0]         pick_ff, pick_in;
   logic               have_ff, have_in;
   logic [LW-1:0]      blen_ff, blen_in;
   logic signed [31:0] bscore_ff, bscore_in;
   logic [31:0]        bid_ff, bid_in;
   logic [31:0]        hash_ff, hash_in;
   logic [FW-1:0]      hk_ff, hk_in;

   // Result registers.
   logic        strobe_ff, strobe_in;
   logic [31:0] tok_ff, tok_in, spos_ff, spos_in, epos_ff, epos_in;
   logic        ltok_ff, ltok_in;

   // Memory ports.
   logic [AW-1:0]                 rd_addr;
   logic [gvpt_pkg::HDR_W-1:0]    hdr_rd;
   logic [7:0]                    byte_rd [MAX_PIECE];
   logic                          accept, idx_ok;

   assign accept = start && !busy;
   assign idx_ok = 32'(req_entry_index) < VOCAB_DEPTH;
   assign rd_addr = scan_ff[AW-1:0];

   // Header store: length, id and score of each entry.
   gvpt_ram #(.WIDTH(gvpt_pkg::HDR_W), .DEPTH(VOCAB_DEPTH), .AW(AW)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (accept && req_kind == gvpt_pkg::KIND_HEADER && idx_ok),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({req_entry_len, req_entry_id, req_entry_score}),
      .rd_addr (rd_addr),
      .rd_data (hdr_rd)
   );

   // Byte store: one lane per piece position, so all bytes of an entry read together.
   for (genvar k = 0; k < MAX_PIECE; k++) begin : g_lane
      gvpt_ram #(.WIDTH(8), .DEPTH(VOCAB_DEPTH), .AW(AW)) u_byte_ram (
         .clock   (clock),
         .wr_en   (accept && req_kind == gvpt_pkg::KIND_BYTE && idx_ok &&
                   32'(req_char_pos) == k),
         .wr_addr (AW'(req_entry_index)),
         .wr_data (req_byte_value),
         .rd_addr (rd_addr),
         .rd_data (byte_rd[k])
      );
   end

   // Entry count clipped to the memory depth.
   logic [CW-1:0] n_entries;
   assign n_entries = (32'(count_ff) > VOCAB_DEPTH) ? CW'(VOCAB_DEPTH) : CW'(count_ff);

   // Prefix compare of the entry just read against the window head.
   logic [LW-1:0] rd_len;
   logic          rd_match, rd_take;
   assign rd_len = hdr_rd[gvpt_pkg::HDR_W-1 -: LW];
   always_comb begin
      rd_match = 1'b1;
      for (int k = 0; k < MAX_PIECE; k++) begin
         if (k < 32'(rd_len) && byte_rd[k] != win_ff[k]) begin
            rd_match = 1'b0;
         end
      end
   end
   assign rd_take = pend_ff && rd_len != '0 && 8'(rd_len) <= 8'(fill_ff) &&
                    !seen_ff[rd_len] && rd_match;

   // Loop condition, now and after the token being emitted.
   logic          more_now, more_next;
   logic [LW-1:0] emit_len;
   logic [FW-1:0] fill_next;
   logic [15:0]   tokens_next;
   assign more_now = tokens_ff < limit_ff &&
                     (32'(fill_ff) >= MAX_PIECE || (last_ff && fill_ff != '0));
   assign emit_len    = (8'(blen_ff) > 8'(fill_ff)) ? LW'(fill_ff) : blen_ff;
   assign fill_next   = fill_ff - FW'(emit_len);
   assign tokens_next = tokens_ff + 16'd1;
   assign more_next = tokens_next < limit_ff &&
                      (32'(fill_next) >= MAX_PIECE || (last_ff && fill_next != '0));

   // Candidate score for the length under the pick counter.
   logic signed [31:0] pick_score;
   assign pick_score = scores_ff ? fscore_ff[pick_ff[LW-1:0]]
                                 : -$signed({10'd0, pick_ff, 16'd0});

   // Next state and data path.
   always_comb begin
      state_in  = state_ff;
      win_in    = win_ff;
      fill_in   = fill_ff;
      offset_in = offset_ff;
      tokens_in = tokens_ff;
      last_in   = last_ff;
      scan_in   = scan_ff;
      pend_in   = 1'b0;
      seen_in   = seen_ff;
      first_we  = 1'b0;
      first_sel = rd_len;
      pick_in   = pick_ff;
      have_in   = have_ff;
      blen_in   = blen_ff;
      bscore_in = bscore_ff;
      bid_in    = bid_ff;
      hash_in   = hash_ff;
      hk_in     = hk_ff;
      strobe_in = 1'b0;
      tok_in    = tok_ff;
      spos_in   = spos_ff;
      epos_in   = epos_ff;
      ltok_in   = ltok_ff;

      unique case (state_ff)
         gvpt_pkg::ST_IDLE: begin
            // A text byte enters the window if room and limit allow; vocabulary words go straight to memory.
            if (accept && req_kind == gvpt_pkg::KIND_TEXT) begin
               if (tokens_ff < limit_ff && 32'(fill_ff) < MAX_PIECE) begin
                  win_in[fill_ff[WIW-1:0]] = req_byte_value;
                  fill_in = fill_ff + FW'(1);
               end
               last_in  = req_last_byte;
               state_in = gvpt_pkg::ST_CHECK;
            end
         end
         gvpt_pkg::ST_CHECK: begin
            // Start another decision, or return to idle, clearing the window after the last byte.
            have_in = 1'b0;
            blen_in = LW'(1);
            seen_in = '0;
            scan_in = '0;
            if (more_now) begin
               if (model_ff && n_entries != '0) begin
                  state_in = gvpt_pkg::ST_SCAN;
               end else begin
                  hash_in  = gvpt_pkg::DJB2_SEED;
                  hk_in    = '0;
                  state_in = gvpt_pkg::ST_HASH;
               end
            end else begin
               if (last_ff) begin
                  for (int k = 0; k < MAX_PIECE; k++) begin
                     win_in[k] = '0;
                  end
                  fill_in   = '0;
                  offset_in = '0;
                  tokens_in = '0;
               end
               state_in = gvpt_pkg::ST_IDLE;
            end
         end
         gvpt_pkg::ST_SCAN: begin
            // One entry read per cycle; the first match of each length is kept.
            if (scan_ff < n_entries) begin
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end
            if (rd_take) begin
               seen_in[rd_len] = 1'b1;
               first_we = 1'b1;
            end
            if (scan_ff >= n_entries && !pend_ff) begin
               pick_in  = 6'd1;
               state_in = gvpt_pkg::ST_PICK;
            end
         end
         gvpt_pkg::ST_PICK: begin
            // Walk the lengths upward; a strictly higher score wins.
            if (8'(pick_ff) <= 8'(fill_ff) && 32'(pick_ff) < NL) begin
               if (seen_ff[pick_ff[LW-1:0]] && (!have_ff || pick_score > bscore_ff)) begin
                  have_in   = 1'b1;
                  bscore_in = pick_score;
                  blen_in   = pick_ff[LW-1:0];
                  bid_in    = fid_ff[pick_ff[LW-1:0]];
               end
               pick_in = pick_ff + 6'd1;
            end else if (have_ff && ids_ff) begin
               state_in = gvpt_pkg::ST_EMIT;
            end else begin
               hash_in  = gvpt_pkg::DJB2_SEED;
               hk_in    = '0;
               state_in = gvpt_pkg::ST_HASH;
            end
         end
         gvpt_pkg::ST_HASH: begin
            // djb2 over the chosen piece, one byte per cycle.
            if (8'(hk_ff) < 8'(blen_ff)) begin
               hash_in = (hash_ff << 5) + hash_ff + 32'(win_ff[hk_ff[WIW-1:0]]);
               hk_in   = hk_ff + FW'(1);
            end else begin
               state_in = gvpt_pkg::ST_EMIT;
            end
         end
         gvpt_pkg::ST_EMIT: begin
            // Present the token and drop its bytes from the window head.
            strobe_in = 1'b1;
            tok_in    = (have_ff && ids_ff) ? bid_ff : hash_ff;
            spos_in   = offset_ff;
            epos_in   = offset_ff + 32'(emit_len);
            ltok_in   = !more_next;
            offset_in = offset_ff + 32'(emit_len);
            tokens_in = tokens_next;
            fill_in   = fill_next;
            for (int k = 0; k < MAX_PIECE; k++) begin
               win_in[k] = (k + 32'(emit_len) < MAX_PIECE) ?
                           win_ff[WIW'(k + 32'(emit_len))] : 8'd0;
            end
            state_in = gvpt_pkg::ST_CHECK;
         end
         default: begin
            state_in = gvpt_pkg::ST_IDLE;
         end
      endcase
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gvpt_pkg::ST_IDLE;
         model_ff  <= 1'b0;
         scores_ff <= 1'b0;
         ids_ff    <= 1'b0;
         count_ff  <= '0;
         limit_ff  <= gvpt_pkg::LIMIT_RESET;
         for (int k = 0; k < MAX_PIECE; k++) begin
            win_ff[k] <= '0;
         end
         fill_ff   <= '0;
         offset_ff <= '0;
         tokens_ff <= '0;
         last_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         win_ff    <= win_in;
         fill_ff   <= fill_in;
         offset_ff <= offset_in;
         tokens_ff <= tokens_in;
         last_ff   <= last_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
         if (csr_we) begin
            unique case (csr_index)
               gvpt_pkg::REG_MODEL:  model_ff  <= csr_wdata[0];
               gvpt_pkg::REG_SCORES: scores_ff <= csr_wdata[0];
               gvpt_pkg::REG_IDS:    ids_ff    <= csr_wdata[0];
               gvpt_pkg::REG_COUNT:  count_ff  <= csr_wdata[10:0];
               gvpt_pkg::REG_LIMIT:  limit_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Decision and result payload registers.
   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      seen_ff   <= seen_in;
      pick_ff   <= pick_in;
      have_ff   <= have_in;
      blen_ff   <= blen_in;
      bscore_ff <= bscore_in;
      bid_ff    <= bid_in;
      hash_ff   <= hash_in;
      hk_ff     <= hk_in;
      tok_ff    <= tok_in;
      spos_ff   <= spos_in;
      epos_ff   <= epos_in;
      ltok_ff   <= ltok_in;
      if (first_we) begin
         fscore_ff[first_sel] <= hdr_rd[31:0];
         fid_ff[first_sel]    <= hdr_rd[63:32];
      end
   end

   assign busy           = state_ff != gvpt_pkg::ST_IDLE;
   assign rsp_strobe     = strobe_ff;
   assign rsp_tok_id     = tok_ff;
   assign rsp_begin_pos  = spos_ff;
   assign rsp_end_pos    = epos_ff;
   assign rsp_last_token = ltok_ff;

endmodule
